[rtl/arc_length_frame_interpolator_macros.svh]
// assertion macros for the arc length frame interpolator
// used by the top level; no dependencies
`ifndef ARC_LENGTH_FRAME_INTERPOLATOR_MACROS_SVH
`define ARC_LENGTH_FRAME_INTERPOLATOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define ALFI_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alfi check failed");
// next-cycle implication, disabled in reset
`define ALFI_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alfi check failed");
`else
`define ALFI_CHECK(lbl, ante, cons)
`define ALFI_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/alfi_pkg.sv]
// shared types and constants of the arc length frame interpolator
// no dependencies
`timescale 1ns / 1ps
package alfi_pkg;
  localparam int MaxPointsDef = 4096;
  localparam int FracBitsDef  = 16;
  localparam int PcW          = 13;   // point_count register width
  localparam int TlW          = 31;   // total_length register width
  localparam int DivW         = 64;   // serial divider dividend / quotient width
  localparam int DenW         = 35;   // serial divider divisor width
  localparam int OpW          = 34;   // blend operand width
  localparam int NormShift    = 28;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic RegPointCount  = 1'b0;
  localparam logic RegTotalLength = 1'b1;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [47:0]        up;
    logic [47:0]        fw;
    logic signed [31:0] arc;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP_LD, S_WRAP_RUN, S_SRCH_ISSUE, S_SRCH_WAIT, S_RD_A, S_RD_B,
    S_LAT_B, S_ALPHA_LD, S_ALPHA_RUN, S_BL_A, S_BL_B, S_BL_ST, S_SQ, S_SQRT,
    S_NDIV_LD, S_NDIV_RUN, S_DWRAP_LD, S_DWRAP_RUN, S_OUT
  } state_t;
endpackage

[rtl/alfi_if.sv]
// valid/ready stream interfaces for load/query transfers and results
// no dependencies
`timescale 1ns / 1ps
interface alfi_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [11:0]        entry_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] heading_x;
  logic signed [15:0] heading_y;
  logic signed [15:0] heading_z;
  logic signed [31:0] arc_position;
  modport source(output valid, action, entry_index, point_x, point_y, point_z,
                 normal_x, normal_y, normal_z, heading_x, heading_y, heading_z,
                 arc_position, input ready);
  modport sink(input valid, action, entry_index, point_x, point_y, point_z,
               normal_x, normal_y, normal_z, heading_x, heading_y, heading_z,
               arc_position, output ready);
endinterface

interface alfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [15:0] out_up_x;
  logic signed [15:0] out_up_y;
  logic signed [15:0] out_up_z;
  logic signed [15:0] out_fw_x;
  logic signed [15:0] out_fw_y;
  logic signed [15:0] out_fw_z;
  logic [30:0]        out_distance;
  modport source(output valid, out_x, out_y, out_z, out_up_x, out_up_y, out_up_z,
                 out_fw_x, out_fw_y, out_fw_z, out_distance, input ready);
  modport sink(input valid, out_x, out_y, out_z, out_up_x, out_up_y, out_up_z,
               out_fw_x, out_fw_y, out_fw_z, out_distance, output ready);
endinterface

[rtl/arc_length_frame_interpolator.sv]
// Arc length frame interpolator. A load transfer writes one table entry. A query's
// binary search makes at most ceil(log2(n+1)) probes, n being the effective entry
// count. One 64-step restoring divider is shared by the distance wrap, the blend
// factor, six vector component divisions and the final distance wrap. Each search
// probe issues a table read and then updates the bounds, the two segment ends are
// read from the table, each of the ten blends runs on the shared multiplier and
// each of the two vector normalizations sums squares and then takes a 32-step
// square root. An empty or reversed segment skips the blend factor division and a
// zero-length vector skips its three divisions. Input is taken only in idle; a
// finished result waits in the output register while the next transfer is taken.
// depends on alfi_pkg, alfi_if and arc_length_frame_interpolator_macros.svh
`timescale 1ns / 1ps
`include "arc_length_frame_interpolator_macros.svh"
module arc_length_frame_interpolator #(
  parameter int MAX_POINTS = alfi_pkg::MaxPointsDef,
  parameter int FRAC_BITS  = alfi_pkg::FracBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  alfi_in_if.sink     in_if,
  alfi_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import alfi_pkg::*;

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW  = AW + 1;
  localparam int WW  = FRAC_BITS + 2;
  localparam int SW  = OpW + WW + 1;
  localparam int DcW = $clog2(DivW + 1);
  localparam logic [FRAC_BITS:0] ONE_A = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  state_t state, state_next;

  // configuration registers and their derived values
  logic [PcW-1:0] pc;
  logic [TlW-1:0] tl;
  logic [TlW-1:0] len;
  logic [NW-1:0]  n_eff;

  // table memory
  entry_t        mem [MAX_POINTS];
  entry_t        rdata;
  logic          ren;
  logic [AW-1:0] raddr;
  logic          wen;
  entry_t        wdata;

  // query working registers
  logic signed [31:0]    d_in;
  logic [TlW-1:0]        d_q;
  logic [NW-1:0]         lo, hi;
  logic [NW:0]           mid_sum;
  logic [AW-1:0]         mid;
  logic [AW-1:0]         i1, i2, i2_r;
  logic                  w_hi, w_lo, w_hi_r, w_lo_r;
  entry_t                ent_a, ent_b;
  logic signed [OpW-1:0] d1, d2;
  logic signed [OpW:0]   span, t_raw;
  logic [OpW:0]          t_clamp;
  logic [FRAC_BITS:0]    alpha;
  logic                  in_acc;

  // blend datapath
  logic [3:0]            bk;
  logic signed [OpW-1:0] op_a, op_b;
  logic signed [WW-1:0]  wa, wb;
  logic signed [SW-1:0]  bl_acc, bl_res;
  logic signed [31:0]    pos_r [3];
  logic signed [17:0]    uv [2][3];
  logic signed [OpW-1:0] dist_b;

  // normalization datapath
  logic                  vsel;
  logic [1:0]            ck;
  logic signed [17:0]    u_cur;
  logic [17:0]           u_mag;
  logic signed [35:0]    sq_prod;
  logic [33:0]           sq_acc, sq_sum;
  logic [63:0]           sq_s, sq_res, sq_bit, sq_trial;
  logic [5:0]            sq_cnt;
  logic                  sq_load;
  logic signed [15:0]    nout [2][3];
  logic [15:0]           q16;

  // shared serial divider
  logic                  div_load;
  logic [DivW-1:0]       div_num, div_quo;
  logic [DenW-1:0]       div_den_in, div_den, div_rem;
  logic [DcW-1:0]        div_cnt;
  logic [DenW:0]         dv_shift, dv_trial;
  logic                  wrap_neg;
  logic [TlW-1:0]        wrap_res;
  logic                  out_load;

  assign in_acc = in_if.valid && in_if.ready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPointCount) ? 32'(pc) : 32'(tl);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PcW'(2);
      tl <= TlW'(65536);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegPointCount:  pc <= pwdata[PcW-1:0];
        RegTotalLength: tl <= pwdata[TlW-1:0];
        default:        ;
      endcase
    end
  end

  // effective length and entry count
  always_comb begin
    len = (tl == '0) ? TlW'(1) : tl;
    if (pc < PcW'(2))                n_eff = NW'(2);
    else if (32'(pc) > MAX_POINTS)   n_eff = NW'(MAX_POINTS);
    else                             n_eff = NW'(pc);
  end

  // table write and registered read
  assign wen = in_acc && (in_if.action == ActLoad) &&
               (32'(in_if.entry_index) < MAX_POINTS);
  assign wdata = '{px: in_if.point_x, py: in_if.point_y, pz: in_if.point_z,
                   up: {in_if.normal_z, in_if.normal_y, in_if.normal_x},
                   fw: {in_if.heading_z, in_if.heading_y, in_if.heading_x},
                   arc: in_if.arc_position};

  always_ff @(posedge clk) begin
    if (wen) mem[AW'(in_if.entry_index)] <= wdata;
    if (ren) rdata <= mem[raddr];
  end

  // search midpoint and segment ends
  always_comb begin
    mid_sum = (NW + 1)'(lo) + (NW + 1)'(hi);
    mid     = mid_sum[AW:1];
    w_hi = 1'b0;
    w_lo = 1'b0;
    if (lo >= n_eff) begin
      i1 = AW'(n_eff - NW'(1));
      i2 = '0;
      w_hi = 1'b1;
    end else if (lo == '0) begin
      i1 = AW'(n_eff - NW'(1));
      i2 = '0;
      w_lo = 1'b1;
    end else begin
      i1 = AW'(lo - NW'(1));
      i2 = AW'(lo);
    end
  end

  // blend factor inputs
  always_comb begin
    span  = (OpW + 1)'(d2) - (OpW + 1)'(d1);
    t_raw = $signed({{(OpW + 1 - TlW){1'b0}}, d_q}) - (OpW + 1)'(d1);
    if (t_raw < 0)         t_clamp = '0;
    else if (t_raw > span) t_clamp = span;
    else                   t_clamp = t_raw;
  end

  // blend operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (bk)
      4'd0: begin op_a = OpW'(ent_a.px); op_b = OpW'(ent_b.px); end
      4'd1: begin op_a = OpW'(ent_a.py); op_b = OpW'(ent_b.py); end
      4'd2: begin op_a = OpW'(ent_a.pz); op_b = OpW'(ent_b.pz); end
      4'd3: begin op_a = OpW'($signed(ent_a.up[15:0]));  op_b = OpW'($signed(ent_b.up[15:0])); end
      4'd4: begin op_a = OpW'($signed(ent_a.up[31:16])); op_b = OpW'($signed(ent_b.up[31:16])); end
      4'd5: begin op_a = OpW'($signed(ent_a.up[47:32])); op_b = OpW'($signed(ent_b.up[47:32])); end
      4'd6: begin op_a = OpW'($signed(ent_a.fw[15:0]));  op_b = OpW'($signed(ent_b.fw[15:0])); end
      4'd7: begin op_a = OpW'($signed(ent_a.fw[31:16])); op_b = OpW'($signed(ent_b.fw[31:16])); end
      4'd8: begin op_a = OpW'($signed(ent_a.fw[47:32])); op_b = OpW'($signed(ent_b.fw[47:32])); end
      4'd9: begin op_a = d1; op_b = d2; end
      default: ;
    endcase
    wa     = $signed(WW'(ONE_A - alpha));
    wb     = $signed(WW'(alpha));
    bl_res = (bl_acc + HALF) >>> FRAC_BITS;
  end

  // normalization arithmetic
  always_comb begin
    u_cur    = uv[vsel][ck];
    u_mag    = u_cur[17] ? 18'(-u_cur) : 18'(u_cur);
    sq_prod  = 36'(u_cur) * 36'(u_cur);
    sq_sum   = sq_acc + sq_prod[33:0];
    sq_trial = sq_res + sq_bit;
    q16      = div_quo[15:0];
  end

  // divider step and wrap correction
  always_comb begin
    dv_shift = {div_rem, div_quo[DivW-1]};
    dv_trial = dv_shift - {1'b0, div_den};
    wrap_res = (wrap_neg && div_rem != '0) ? TlW'(len - div_rem[TlW-1:0])
                                           : div_rem[TlW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_acc && in_if.action == ActQuery) state_next = S_WRAP_LD;
      S_WRAP_LD:    state_next = S_WRAP_RUN;
      S_WRAP_RUN:   if (div_cnt == '0) state_next = S_SRCH_ISSUE;
      S_SRCH_ISSUE: state_next = (lo < hi) ? S_SRCH_WAIT : S_RD_A;
      S_SRCH_WAIT:  state_next = S_SRCH_ISSUE;
      S_RD_A:       state_next = S_RD_B;
      S_RD_B:       state_next = S_LAT_B;
      S_LAT_B:      state_next = S_ALPHA_LD;
      S_ALPHA_LD:   state_next = (span <= 0) ? S_BL_A : S_ALPHA_RUN;
      S_ALPHA_RUN:  if (div_cnt == '0) state_next = S_BL_A;
      S_BL_A:       state_next = S_BL_B;
      S_BL_B:       state_next = S_BL_ST;
      S_BL_ST:      state_next = (bk == 4'd9) ? S_SQ : S_BL_A;
      S_SQ:         if (ck == 2'd2) state_next = S_SQRT;
      S_SQRT: begin
        if (sq_cnt == '0) begin
          if (sq_res != '0)  state_next = S_NDIV_LD;
          else if (vsel)     state_next = S_DWRAP_LD;
          else               state_next = S_SQ;
        end
      end
      S_NDIV_LD:    state_next = S_NDIV_RUN;
      S_NDIV_RUN: begin
        if (div_cnt == '0) begin
          if (ck != 2'd2) state_next = S_NDIV_LD;
          else if (vsel)  state_next = S_DWRAP_LD;
          else            state_next = S_SQ;
        end
      end
      S_DWRAP_LD:   state_next = S_DWRAP_RUN;
      S_DWRAP_RUN:  if (div_cnt == '0) state_next = S_OUT;
      S_OUT:        if (!out_if.valid || out_if.ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_if.ready = (state == S_IDLE);
    ren         = 1'b0;
    raddr       = '0;
    div_load    = 1'b0;
    div_num     = '0;
    div_den_in  = DenW'(len);
    sq_load     = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      S_WRAP_LD: begin
        div_load = 1'b1;
        div_num  = DivW'(d_in[31] ? $unsigned(-d_in) : $unsigned(d_in));
      end
      S_SRCH_ISSUE: begin
        ren   = (lo < hi);
        raddr = mid;
      end
      S_RD_A: begin
        ren   = 1'b1;
        raddr = i1;
      end
      S_RD_B: begin
        ren   = 1'b1;
        raddr = i2_r;
      end
      S_ALPHA_LD: begin
        div_load   = (span > 0);
        div_num    = DivW'(t_clamp) << FRAC_BITS;
        div_den_in = DenW'(span);
      end
      S_SQ: sq_load = (ck == 2'd2);
      S_NDIV_LD: begin
        div_load   = 1'b1;
        div_num    = (DivW'(u_mag) << NormShift) + DivW'(sq_res >> 1);
        div_den_in = DenW'(sq_res);
      end
      S_DWRAP_LD: begin
        div_load = 1'b1;
        div_num  = DivW'(dist_b[OpW-1] ? OpW'(-dist_b) : OpW'(dist_b));
      end
      S_OUT: out_load = !out_if.valid || out_if.ready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      div_cnt       <= '0;
      sq_cnt        <= '0;
      bk            <= '0;
      ck            <= '0;
      vsel          <= 1'b0;
      lo            <= '0;
      hi            <= '0;
      out_if.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (div_load)           div_cnt <= DcW'(DivW);
      else if (div_cnt != '0) div_cnt <= div_cnt - DcW'(1);
      if (sq_load)            sq_cnt <= 6'd32;
      else if (sq_cnt != '0)  sq_cnt <= sq_cnt - 6'd1;
      if (out_load)           out_if.valid <= 1'b1;
      else if (out_if.ready)  out_if.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          bk   <= '0;
          ck   <= '0;
          vsel <= 1'b0;
        end
        S_WRAP_RUN: if (div_cnt == '0) begin
          lo <= '0;
          hi <= n_eff;
        end
        S_SRCH_WAIT: begin
          if ($signed({rdata.arc[31], rdata.arc}) < $signed({2'b00, d_q}))
            lo <= NW'(mid) + NW'(1);
          else
            hi <= NW'(mid);
        end
        S_BL_ST: bk <= bk + 4'd1;
        S_SQ:    ck <= (ck == 2'd2) ? 2'd0 : ck + 2'd1;
        S_SQRT: if (sq_cnt == '0 && sq_res == '0) vsel <= 1'b1;
        S_NDIV_RUN: if (div_cnt == '0) begin
          ck <= (ck == 2'd2) ? 2'd0 : ck + 2'd1;
          if (ck == 2'd2) vsel <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // serial divider
    if (div_load) begin
      div_quo <= div_num;
      div_rem <= '0;
      div_den <= div_den_in;
    end else if (div_cnt != '0) begin
      if (!dv_trial[DenW]) begin
        div_rem <= dv_trial[DenW-1:0];
        div_quo <= {div_quo[DivW-2:0], 1'b1};
      end else begin
        div_rem <= dv_shift[DenW-1:0];
        div_quo <= {div_quo[DivW-2:0], 1'b0};
      end
    end
    // serial square root
    if (sq_load) begin
      sq_s   <= 64'(sq_sum) << NormShift;
      sq_res <= '0;
      sq_bit <= 64'(1) << 62;
    end else if (sq_cnt != '0) begin
      if (sq_s >= sq_trial) begin
        sq_s   <= sq_s - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    unique case (state)
      S_IDLE: if (in_acc) d_in <= in_if.arc_position;
      S_WRAP_LD:  wrap_neg <= d_in[31];
      S_WRAP_RUN: if (div_cnt == '0) d_q <= wrap_res;
      S_RD_A: begin
        i2_r   <= i2;
        w_hi_r <= w_hi;
        w_lo_r <= w_lo;
      end
      S_RD_B: ent_a <= rdata;
      S_LAT_B: begin
        ent_b <= rdata;
        d1 <= OpW'(ent_a.arc) - (w_lo_r ? OpW'(len) : OpW'(0));
        d2 <= OpW'(rdata.arc) + (w_hi_r ? OpW'(len) : OpW'(0));
      end
      S_ALPHA_LD:  if (span <= 0) alpha <= ONE_A;
      S_ALPHA_RUN: if (div_cnt == '0) alpha <= div_quo[FRAC_BITS:0];
      S_BL_A: bl_acc <= SW'(op_a) * SW'(wa);
      S_BL_B: bl_acc <= bl_acc + SW'(op_b) * SW'(wb);
      S_BL_ST: begin
        unique case (bk)
          4'd0: pos_r[0] <= bl_res[31:0];
          4'd1: pos_r[1] <= bl_res[31:0];
          4'd2: pos_r[2] <= bl_res[31:0];
          4'd3: uv[0][0] <= bl_res[17:0];
          4'd4: uv[0][1] <= bl_res[17:0];
          4'd5: uv[0][2] <= bl_res[17:0];
          4'd6: uv[1][0] <= bl_res[17:0];
          4'd7: uv[1][1] <= bl_res[17:0];
          4'd8: uv[1][2] <= bl_res[17:0];
          4'd9: dist_b   <= bl_res[OpW-1:0];
          default: ;
        endcase
      end
      S_SQ: sq_acc <= (ck == 2'd0) ? 34'(sq_prod[33:0]) : sq_sum;
      S_SQRT: if (sq_cnt == '0 && sq_res == '0) begin
        nout[vsel][0] <= '0;
        nout[vsel][1] <= '0;
        nout[vsel][2] <= '0;
      end
      S_NDIV_LD: wrap_neg <= u_cur[17];
      S_NDIV_RUN: if (div_cnt == '0) nout[vsel][ck] <= wrap_neg ? -q16 : q16;
      S_DWRAP_LD: wrap_neg <= dist_b[OpW-1];
      default: ;
    endcase
    // result register
    if (out_load) begin
      out_if.out_x        <= pos_r[0];
      out_if.out_y        <= pos_r[1];
      out_if.out_z        <= pos_r[2];
      out_if.out_up_x     <= nout[0][0];
      out_if.out_up_y     <= nout[0][1];
      out_if.out_up_z     <= nout[0][2];
      out_if.out_fw_x     <= nout[1][0];
      out_if.out_fw_y     <= nout[1][1];
      out_if.out_fw_z     <= nout[1][2];
      out_if.out_distance <= wrap_res;
    end
  end

  // checks
  `ALFI_CHECK(a_srch_bounds, state == S_SRCH_ISSUE, lo <= hi && hi <= n_eff)
  `ALFI_CHECK(a_alpha_range, state == S_BL_A, alpha <= ONE_A)
  `ALFI_CHECK(a_div_free, div_load, div_cnt == '0)
  `ALFI_CHECK(a_sqrt_free, sq_load, sq_cnt == '0)
  `ALFI_CHECK_NEXT(a_query_start, in_acc && in_if.action == ActQuery, state == S_WRAP_LD)
endmodule
